// ----- rtl/hpiir3_pkg.sv -----
// hpiir3_pkg: shared constants and types for the third-order high-pass iir block
// no dependencies; imported by the interfaces and by the top, front and back modules of the block
`default_nettype none

package hpiir3_pkg;

   localparam int COEF_BITS      = 32;
   localparam int COEF_FRAC      = 28;
   localparam int OUT_FRAC       = 8;
   localparam int CHAN_BITS      = 3;
   localparam int CSR_INDEX_BITS = 3;

   // register indexes of the csr port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_B0 = 3'd0,
      REG_B2 = 3'd1,
      REG_A1 = 3'd2,
      REG_A2 = 3'd3,
      REG_A3 = 3'd4
   } csr_reg_type;

   typedef logic signed [COEF_BITS-1:0] coef_type;

   typedef struct packed {
      coef_type b0;
      coef_type b2;
      coef_type a1;
      coef_type a2;
      coef_type a3;
   } coef_set_type;

   // q3.28 reset values
   localparam coef_type B0_RESET = 32'sh1000_0000;
   localparam coef_type B2_RESET = 32'sh3000_0000;
   localparam coef_type A_RESET  = 32'sh0000_0000;

endpackage

`default_nettype wire

// ----- rtl/hpiir3_if.sv -----
// hpiir3 channel interfaces: request, response and csr write channels
// depends on hpiir3_pkg for field widths
`default_nettype none

interface hpiir3_req_if import hpiir3_pkg::*; #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [CHAN_BITS-1:0]          channel_index;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, channel_index, sample_in, input ready);
   modport sink   (input valid, channel_index, sample_in, output ready);
endinterface

interface hpiir3_rsp_if import hpiir3_pkg::*; #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [CHAN_BITS-1:0]          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          saturated;

   modport source (output valid, channel_out, sample_out, saturated, input ready);
   modport sink   (input valid, channel_out, sample_out, saturated, output ready);
endinterface

interface hpiir3_csr_if import hpiir3_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [COEF_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/third_order_highpass_iir.sv -----
// third_order_highpass_iir: top level of the multichannel third-order high-pass iir
// depends on hpiir3_pkg, hpiir3_if, hpiir3_front and hpiir3_back
`default_nettype none

// Multichannel third-order high-pass IIR in direct form I. Each request transaction
// carries a channel index and a signed sample; each produces exactly one response
// transaction with the same channel index, the filtered sample rounded half up and
// saturated to SAMPLE_BITS, and a flag set when it was clipped. Channel indexes at
// or beyond CHANNELS wrap modulo CHANNELS. Coefficients are signed Q3.28 in five csr
// registers (0 b0, 1 b2, 2 a1, 3 a2, 4 a3); writes to other indexes are dropped,
// and csr writes are expected only while no transaction is in flight. Throughput is
// one transaction per clock while responses are not stalled and no channel repeats
// within the three stages behind the state ram read; a channel that follows itself
// waits for its state write-back before its next sample is read. Channel state sits in
// one ram row per channel, cleared at reset through per-row valid bits, so there is
// no clearing pass and requests are taken right after reset.
module third_order_highpass_iir import hpiir3_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24
) (
   input  logic          clock,
   input  logic          reset,
   hpiir3_req_if.sink    req_bus,
   hpiir3_rsp_if.source  rsp_bus,
   hpiir3_csr_if.sink    csr_bus
);

   localparam int ADDR_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // queue between front and back
   logic                          q_valid;
   logic                          q_pop;
   logic [CHAN_BITS-1:0]          q_chan;
   logic [ADDR_BITS-1:0]          q_addr;
   logic signed [SAMPLE_BITS-1:0] q_sample;

   coef_set_type coefs_ff, coefs_in;

   // csr port never stalls
   assign csr_bus.ready = 1'b1;

   always_comb begin
      coefs_in = coefs_ff;
      if (csr_bus.valid) begin
         unique case (csr_reg_type'(csr_bus.index))
            REG_B0:  coefs_in.b0 = coef_type'(csr_bus.data);
            REG_B2:  coefs_in.b2 = coef_type'(csr_bus.data);
            REG_A1:  coefs_in.a1 = coef_type'(csr_bus.data);
            REG_A2:  coefs_in.a2 = coef_type'(csr_bus.data);
            REG_A3:  coefs_in.a3 = coef_type'(csr_bus.data);
            default: coefs_in = coefs_ff;   // unmapped index, write ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_ff.b0 <= B0_RESET;
         coefs_ff.b2 <= B2_RESET;
         coefs_ff.a1 <= A_RESET;
         coefs_ff.a2 <= A_RESET;
         coefs_ff.a3 <= A_RESET;
      end else begin
         coefs_ff <= coefs_in;
      end
   end

   // front: accept, map channel to state row, queue
   hpiir3_front #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_chan   (req_bus.channel_index),
      .req_sample (req_bus.sample_in),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_chan     (q_chan),
      .q_addr     (q_addr),
      .q_sample   (q_sample)
   );

   // back: state read, multiply, sum, round/saturate, write-back, response
   hpiir3_back #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .coefs      (coefs_ff),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_chan     (q_chan),
      .q_addr     (q_addr),
      .q_sample   (q_sample),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_chan   (rsp_bus.channel_out),
      .rsp_sample (rsp_bus.sample_out),
      .rsp_sat    (rsp_bus.saturated)
   );

endmodule

`default_nettype wire

// ----- rtl/hpiir3_ram.sv -----
// hpiir3_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module hpiir3_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 8,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/hpiir3_front.sv -----
// hpiir3_front: accepts request transactions, maps the channel to a state row,
// and holds them in a two-entry queue for the back end; depends on hpiir3_pkg
`default_nettype none

module hpiir3_front import hpiir3_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CHAN_BITS-1:0]          req_chan,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          q_valid,
   input  logic                          q_pop,
   output logic [CHAN_BITS-1:0]          q_chan,
   output logic [ADDR_BITS-1:0]          q_addr,
   output logic signed [SAMPLE_BITS-1:0] q_sample
);

   localparam logic [6:0] CH7 = 7'(CHANNELS);

   // channel field modulo CHANNELS by repeated subtraction
   function automatic logic [ADDR_BITS-1:0] chan_to_addr(input logic [CHAN_BITS-1:0] c);
      logic [6:0] v;
      v = 7'(c);
      for (int i = 0; i < (1 << CHAN_BITS); i++) begin
         if (v >= CH7) begin
            v = v - CH7;
         end
      end
      return v[ADDR_BITS-1:0];
   endfunction

   logic [CHAN_BITS-1:0]          chan_ff   [2];
   logic [ADDR_BITS-1:0]          addr_ff   [2];
   logic signed [SAMPLE_BITS-1:0] sample_ff [2];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [1:0]                    count_ff, count_in;
   logic                          push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_chan    = chan_ff[rd_ptr_ff];
   assign q_addr    = addr_ff[rd_ptr_ff];
   assign q_sample  = sample_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         chan_ff[wr_ptr_ff]   <= req_chan;
         addr_ff[wr_ptr_ff]   <= chan_to_addr(req_chan);
         sample_ff[wr_ptr_ff] <= req_sample;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hpiir3_back.sv -----
// hpiir3_back: state ram, multiply, sum and round/saturate pipeline with the
// response register; depends on hpiir3_pkg and hpiir3_ram
`default_nettype none

module hpiir3_back import hpiir3_pkg::*; #(
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_BITS = 24,
   parameter int ADDR_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  coef_set_type                  coefs,
   input  logic                          q_valid,
   output logic                          q_pop,
   input  logic [CHAN_BITS-1:0]          q_chan,
   input  logic [ADDR_BITS-1:0]          q_addr,
   input  logic signed [SAMPLE_BITS-1:0] q_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CHAN_BITS-1:0]          rsp_chan,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_sat
);

   localparam int SB  = SAMPLE_BITS;
   localparam int YB  = SB + OUT_FRAC;              // stored output width
   localparam int DB  = SB + 1;                     // input difference width
   localparam int FFP = COEF_BITS + DB;             // feed-forward product
   localparam int FBP = COEF_BITS + YB;             // feedback product
   localparam int ACC = COEF_BITS + SB + 4;         // accumulator
   localparam int ROW = 3 * SB + 3 * YB;            // one channel's state row
   localparam int RW  = ACC - COEF_FRAC;            // sample before clamp
   localparam int YS  = COEF_FRAC - OUT_FRAC;       // shift for stored output
   localparam int YRW = ACC - YS;                   // stored output before clamp

   localparam logic signed [ACC-1:0] HALF_S =
      {{(ACC-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
   localparam logic signed [ACC-1:0] HALF_Y =
      {{(ACC-YS){1'b0}}, 1'b1, {(YS-1){1'b0}}};
   localparam logic signed [RW-1:0]  SMAX = RW'({1'b0, {(SB-1){1'b1}}});
   localparam logic signed [RW-1:0]  SMIN = ~SMAX;
   localparam logic signed [YRW-1:0] YMAX = YRW'({1'b0, {(YB-1){1'b1}}});
   localparam logic signed [YRW-1:0] YMIN = ~YMAX;

   logic adv, hazard, issue, wr_en;

   // stage 1: state row read
   logic                   s1_valid_ff, s1_valid_in;
   logic [CHAN_BITS-1:0]   s1_chan_ff;
   logic [ADDR_BITS-1:0]   s1_addr_ff;
   logic signed [SB-1:0]   s1_x_ff;
   logic                   s1_row_valid_ff;
   logic [ROW-1:0]         rd_row;
   logic signed [SB-1:0]   x1, x2, x3;
   logic signed [YB-1:0]   y1, y2, y3;
   logic signed [DB-1:0]   d0, d2;

   // stage 2: products
   logic                   s2_valid_ff;
   logic [CHAN_BITS-1:0]   s2_chan_ff;
   logic [ADDR_BITS-1:0]   s2_addr_ff;
   logic signed [SB-1:0]   s2_x_ff, s2_x1_ff, s2_x2_ff;
   logic signed [YB-1:0]   s2_y1_ff, s2_y2_ff;
   logic signed [FFP-1:0]  s2_pb0_ff, s2_pb2_ff, s2_pb0_in, s2_pb2_in;
   logic signed [FBP-1:0]  s2_pa1_ff, s2_pa2_ff, s2_pa3_ff;
   logic signed [FBP-1:0]  s2_pa1_in, s2_pa2_in, s2_pa3_in;

   // stage 3: accumulator
   logic                   s3_valid_ff;
   logic [CHAN_BITS-1:0]   s3_chan_ff;
   logic [ADDR_BITS-1:0]   s3_addr_ff;
   logic signed [SB-1:0]   s3_x_ff, s3_x1_ff, s3_x2_ff;
   logic signed [YB-1:0]   s3_y1_ff, s3_y2_ff;
   logic signed [ACC-1:0]  s3_acc_ff, s3_acc_in;
   logic signed [ACC-1:0]  acc_rs, acc_ry;
   logic signed [RW-1:0]   rs;
   logic signed [YRW-1:0]  ry;
   logic signed [SB-1:0]   sample_sat;
   logic signed [YB-1:0]   y_new;
   logic                   sat;
   logic [ROW-1:0]         wr_row;

   // response register and row valid bits
   logic                   rsp_valid_ff;
   logic [CHAN_BITS-1:0]   rsp_chan_ff;
   logic signed [SB-1:0]   rsp_sample_ff;
   logic                   rsp_sat_ff;
   logic [CHANNELS-1:0]    row_valid_ff, row_valid_in;

   assign adv    = !rsp_valid_ff || rsp_ready;
   assign hazard = (s1_valid_ff && (s1_addr_ff == q_addr))
                || (s2_valid_ff && (s2_addr_ff == q_addr))
                || (s3_valid_ff && (s3_addr_ff == q_addr));
   assign issue  = adv && q_valid && !hazard;
   assign q_pop  = issue;
   assign wr_en  = adv && s3_valid_ff;

   hpiir3_ram #(
      .WIDTH (ROW),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (s3_addr_ff),
      .wdata (wr_row),
      .re    (issue),
      .raddr (q_addr),
      .rdata (rd_row)
   );

   // stage 1 datapath
   assign {x1, x2, x3, y1, y2, y3} = s1_row_valid_ff ? rd_row : '0;

   always_comb begin
      s1_valid_in = issue;
      d0          = DB'(s1_x_ff) - DB'(x3);
      d2          = DB'(x2) - DB'(x1);
      s2_pb0_in   = FFP'(coefs.b0) * FFP'(d0);
      s2_pb2_in   = FFP'(coefs.b2) * FFP'(d2);
      s2_pa1_in   = FBP'(coefs.a1) * FBP'(y1);
      s2_pa2_in   = FBP'(coefs.a2) * FBP'(y2);
      s2_pa3_in   = FBP'(coefs.a3) * FBP'(y3);
   end

   // stage 2 datapath
   always_comb begin
      s3_acc_in = ACC'(s2_pb0_ff) + ACC'(s2_pb2_ff)
                - ACC'(s2_pa1_ff >>> OUT_FRAC)
                - ACC'(s2_pa2_ff >>> OUT_FRAC)
                - ACC'(s2_pa3_ff >>> OUT_FRAC);
   end

   // stage 3 datapath: round half up, clamp, build the write-back row
   always_comb begin
      acc_rs = s3_acc_ff + HALF_S;
      acc_ry = s3_acc_ff + HALF_Y;
      rs     = RW'(acc_rs >>> COEF_FRAC);
      ry     = YRW'(acc_ry >>> YS);
      sat    = (rs > SMAX) || (rs < SMIN);
      if (rs > SMAX) begin
         sample_sat = SMAX[SB-1:0];
      end else if (rs < SMIN) begin
         sample_sat = SMIN[SB-1:0];
      end else begin
         sample_sat = rs[SB-1:0];
      end
      if (ry > YMAX) begin
         y_new = YMAX[YB-1:0];
      end else if (ry < YMIN) begin
         y_new = YMIN[YB-1:0];
      end else begin
         y_new = ry[YB-1:0];
      end
      wr_row = {s3_x_ff, s3_x1_ff, s3_x2_ff, y_new, s3_y1_ff, s3_y2_ff};
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[s3_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
         if (adv) begin
            s1_valid_ff  <= s1_valid_in;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_chan_ff      <= q_chan;
         s1_addr_ff      <= q_addr;
         s1_x_ff         <= q_sample;
         s1_row_valid_ff <= row_valid_ff[q_addr];
      end
      if (adv) begin
         s2_chan_ff    <= s1_chan_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_x_ff       <= s1_x_ff;
         s2_x1_ff      <= x1;
         s2_x2_ff      <= x2;
         s2_y1_ff      <= y1;
         s2_y2_ff      <= y2;
         s2_pb0_ff     <= s2_pb0_in;
         s2_pb2_ff     <= s2_pb2_in;
         s2_pa1_ff     <= s2_pa1_in;
         s2_pa2_ff     <= s2_pa2_in;
         s2_pa3_ff     <= s2_pa3_in;
         s3_chan_ff    <= s2_chan_ff;
         s3_addr_ff    <= s2_addr_ff;
         s3_x_ff       <= s2_x_ff;
         s3_x1_ff      <= s2_x1_ff;
         s3_x2_ff      <= s2_x2_ff;
         s3_y1_ff      <= s2_y1_ff;
         s3_y2_ff      <= s2_y2_ff;
         s3_acc_ff     <= s3_acc_in;
         rsp_chan_ff   <= s3_chan_ff;
         rsp_sample_ff <= sample_sat;
         rsp_sat_ff    <= sat;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_chan   = rsp_chan_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_sat    = rsp_sat_ff;

endmodule

`default_nettype wire

// ----- tb/third_order_highpass_iir_test.sv -----
// testbench for third_order_highpass_iir: drives sample transactions and checks each response
// against an in-bench fixed-point copy of the filter; depends on hpiir3_pkg and hpiir3_if
module third_order_highpass_iir_test;
   import hpiir3_pkg::*;

   localparam int CHANNELS    = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
   localparam longint STATE_HI  = (longint'(1) <<< (SAMPLE_BITS - 1 + OUT_FRAC)) - 1;
   localparam longint STATE_LO  = -STATE_HI - 1;
   localparam longint HALF_OUT_LSB   = longint'(1) <<< (COEF_FRAC - 1);
   localparam longint HALF_STATE_LSB = longint'(1) <<< (COEF_FRAC - OUT_FRAC - 1);
   localparam coef_type COEF_MAX  = 32'sh7FFF_FFFF;
   localparam coef_type COEF_MIN  = 32'sh8000_0000;
   localparam coef_type COEF_HALF = 32'sh0800_0000;
   localparam real PI = 3.14159265358979;

   typedef struct packed {
      logic [CHAN_BITS-1:0]          chan;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          sat;
   } filtered_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hpiir3_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   hpiir3_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_bus ();
   hpiir3_csr_if csr_bus ();

   third_order_highpass_iir #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #1 clock = ~clock;

   // filter state mirror: coefficients plus three past inputs and outputs per channel
   coef_set_type                  coefs = '{b0: B0_RESET, b2: B2_RESET,
                                            a1: A_RESET, a2: A_RESET, a3: A_RESET};
   logic signed [SAMPLE_BITS-1:0] x_hist [CHANNELS][3] = '{default: '0};
   logic signed [31:0]            y_hist [CHANNELS][3] = '{default: '0};

   filtered_type pending_outputs [$];
   int           error_count = 0;
   int           cycle_count = 0;
   logic [CHAN_BITS-1:0] last_chan = '0;

   // idling knobs, flipped by the tests
   bit req_gaps_on   = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold_cycles = 0;
   int rsp_stall_left  = 0;
   int unsigned rsp_roll;

   // y = b0*(x - x3) + b2*(x2 - x1) - sum(a_k*y_k >> 8), scale 2^28
   function automatic filtered_type filter_sample(input logic [CHAN_BITS-1:0] chan,
                                                  input logic signed [SAMPLE_BITS-1:0] x);
      longint       acc, rounded, clipped, y_next;
      int unsigned  c;
      filtered_type r;
      c = chan % CHANNELS;
      acc = longint'(coefs.b0) * (longint'(x) - longint'(x_hist[c][2]))
          + longint'(coefs.b2) * (longint'(x_hist[c][1]) - longint'(x_hist[c][0]));
      // feedback products floored to the 2^28 scale before summing
      acc = acc - ((longint'(coefs.a1) * longint'(y_hist[c][0])) >>> OUT_FRAC);
      acc = acc - ((longint'(coefs.a2) * longint'(y_hist[c][1])) >>> OUT_FRAC);
      acc = acc - ((longint'(coefs.a3) * longint'(y_hist[c][2])) >>> OUT_FRAC);

      // round half up, then clip to the sample range
      rounded = (acc + HALF_OUT_LSB) >>> COEF_FRAC;
      clipped = (rounded > SAMPLE_HI) ? SAMPLE_HI : (rounded < SAMPLE_LO) ? SAMPLE_LO : rounded;

      // stored output keeps 8 fraction bits and is clipped too
      y_next = (acc + HALF_STATE_LSB) >>> (COEF_FRAC - OUT_FRAC);
      y_next = (y_next > STATE_HI) ? STATE_HI : (y_next < STATE_LO) ? STATE_LO : y_next;

      y_hist[c][2] = y_hist[c][1];
      y_hist[c][1] = y_hist[c][0];
      y_hist[c][0] = y_next[31:0];
      x_hist[c][2] = x_hist[c][1];
      x_hist[c][1] = x_hist[c][0];
      x_hist[c][0] = x;

      r.chan   = chan;
      r.sample = clipped[SAMPLE_BITS-1:0];
      r.sat    = (clipped != rounded);
      return r;
   endfunction

   // mix of rail values, full-scale noise and small amplitudes
   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      logic signed [SAMPLE_BITS-1:0] v;
      int unsigned pick, drop;
      pick = $urandom_range(0, 99);
      v = SAMPLE_BITS'($urandom);
      if (pick < 8) begin
         v = SAMPLE_MAX;
      end else if (pick < 16) begin
         v = SAMPLE_MIN;
      end else if (pick < 60) begin
         drop = $urandom_range(0, SAMPLE_BITS - 1);
         v = v <<< drop;
         v = v >>> drop;
      end
      return v;
   endfunction

   function automatic coef_type to_q328(input real v);
      return coef_type'($rtoi(v * (2.0 ** COEF_FRAC)));
   endfunction

   // one request transaction; valid stays high afterwards so the next one can follow directly
   task automatic send_sample(input logic [CHAN_BITS-1:0] chan,
                              input logic signed [SAMPLE_BITS-1:0] value);
      int unsigned gap, roll;
      gap = 0;
      if (req_gaps_on) begin
         roll = $urandom_range(0, 99);
         if (roll >= 95) begin
            gap = $urandom_range(8, 30);
         end else if (roll >= 75) begin
            gap = $urandom_range(1, 3);
         end
      end
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.channel_index <= chan;
      req_bus.sample_in     <= value;
      do @(posedge clock); while (!req_bus.ready);
      pending_outputs.push_back(filter_sample(chan, value));
      last_chan = chan;
   endtask

   task automatic hold_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // idle the block: no request in flight and every response back
   task automatic drain_outputs();
      hold_requests();
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index, input coef_type value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         REG_B0: coefs.b0 = value;
         REG_B2: coefs.b2 = value;
         REG_A1: coefs.a1 = value;
         REG_A2: coefs.a2 = value;
         REG_A3: coefs.a3 = value;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_coefficients(input coef_type b0, input coef_type b2,
                                     input coef_type a1, input coef_type a2,
                                     input coef_type a3);
      drain_outputs();
      write_register(REG_B0, b0);
      write_register(REG_B2, b2);
      write_register(REG_A1, a1);
      write_register(REG_A2, a2);
      write_register(REG_A3, a3);
   endtask

   task automatic send_random_samples(input int count);
      logic [CHAN_BITS-1:0] chan;
      repeat (count) begin
         // a quarter of the time repeat the channel to hit the state write-back hazard
         if ($urandom_range(0, 3) == 0) begin
            chan = last_chan;
         end else begin
            chan = CHAN_BITS'($urandom_range(0, CHANNELS - 1));
         end
         send_sample(chan, random_sample());
      end
   endtask

   // reset coefficients give the plain (1, -3, 3, -1) difference; rails saturate both ways
   task automatic check_reset_coefficients();
      send_sample(CHAN_BITS'(0), SAMPLE_MAX);
      send_sample(CHAN_BITS'(0), SAMPLE_MIN);
      send_sample(CHAN_BITS'(0), SAMPLE_MAX);
      send_sample(CHAN_BITS'(0), SAMPLE_MIN);
      send_sample(CHAN_BITS'(0), '0);
      send_sample(CHAN_BITS'(7), SAMPLE_BITS'(1));
      send_sample(CHAN_BITS'(7), SAMPLE_BITS'(-1));
      send_sample(CHAN_BITS'(7), SAMPLE_MIN);
      for (int c = 1; c < 7; c++) begin
         send_sample(CHAN_BITS'(c), c[0] ? SAMPLE_MAX : SAMPLE_MIN);
      end
   endtask

   // b0 = 0.5 alone: +0.5 rounds up to 1, -0.5 rounds up to 0
   task automatic check_rounding();
      write_coefficients(COEF_HALF, A_RESET, A_RESET, A_RESET, A_RESET);
      repeat (3) send_sample(CHAN_BITS'(5), '0);
      send_sample(CHAN_BITS'(5), SAMPLE_BITS'(1));
      send_sample(CHAN_BITS'(5), SAMPLE_BITS'(-1));
      send_sample(CHAN_BITS'(5), SAMPLE_BITS'(1));
      send_sample(CHAN_BITS'(5), SAMPLE_BITS'(-1));
   endtask

   // writes above the last register must leave the coefficients alone
   task automatic check_unmapped_registers();
      drain_outputs();
      for (int idx = int'(REG_A3) + 1; idx < (1 << CSR_INDEX_BITS); idx++) begin
         write_register(idx[CSR_INDEX_BITS-1:0], COEF_MAX);
      end
      send_random_samples(4);
   endtask

   task automatic check_coefficient_extremes();
      write_coefficients(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      send_random_samples(15);
      write_coefficients(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      send_random_samples(15);
      write_coefficients(COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
      send_random_samples(15);
      write_coefficients(A_RESET, A_RESET, A_RESET, A_RESET, A_RESET);
      send_random_samples(15);
   endtask

   // realistic bilinear designs at several cutoffs, idling on for every other one
   task automatic check_butterworth_streams();
      real cutoffs [5] = '{0.01, 0.05, 0.15, 0.3, 0.45};
      real k, k2, k3, a0;
      foreach (cutoffs[i]) begin
         k  = $tan(PI * cutoffs[i]);
         k2 = k * k;
         k3 = k2 * k;
         a0 = k3 + 2.0 * k2 + 2.0 * k + 1.0;
         write_coefficients(to_q328(1.0 / a0), to_q328(3.0 / a0),
                            to_q328((3.0 * k3 + 2.0 * k2 - 2.0 * k - 3.0) / a0),
                            to_q328((3.0 * k3 - 2.0 * k2 - 2.0 * k + 3.0) / a0),
                            to_q328((k3 - 2.0 * k2 + 2.0 * k - 1.0) / a0));
         req_gaps_on   = (i % 2 == 0);
         rsp_stalls_on = (i % 2 == 0);
         send_random_samples(160);
      end
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // receiver blocks for a long stretch while requests keep coming, so the block fills up
   task automatic check_output_backpressure();
      rsp_hold_cycles = 300;
      req_gaps_on = 1'b0;
      send_random_samples(40);
      req_gaps_on = 1'b1;
   endtask

   // sender stops until every response is back, then resumes
   task automatic check_sender_pause();
      send_random_samples(30);
      hold_requests();
      while (pending_outputs.size() != 0) @(posedge clock);
      send_random_samples(30);
   endtask

   task automatic check_random_coefficients();
      repeat (3) begin
         write_coefficients($urandom, $urandom, $urandom, $urandom, $urandom);
         send_random_samples(30);
      end
   endtask

   // response ready: random stalls, mostly short, plus the long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else if (rsp_stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall_left = rsp_stall_left - 1;
      end else if (rsp_stalls_on) begin
         rsp_roll = $urandom_range(0, 99);
         if (rsp_roll < 80) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b0;
            rsp_stall_left = (rsp_roll < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
         end
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // response check: each transaction against the oldest expected sample
   always @(posedge clock) begin : response_check
      filtered_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outputs.size() == 0) begin
            $error("response transaction with nothing pending: channel_out %0d sample_out %0d",
                   rsp_bus.channel_out, rsp_bus.sample_out);
            error_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_bus.channel_out !== want.chan) begin
               $error("channel_out: expected %0d, actual %0d", want.chan, rsp_bus.channel_out);
               error_count++;
            end
            if (rsp_bus.sample_out !== want.sample) begin
               $error("sample_out: expected %0d, actual %0d", want.sample, rsp_bus.sample_out);
               error_count++;
            end
            if (rsp_bus.saturated !== want.sat) begin
               $error("saturated: expected %0d, actual %0d", want.sat, rsp_bus.saturated);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL third_order_highpass_iir");
         $finish;
      end
   end

   initial begin
      req_bus.valid         = 1'b0;
      req_bus.channel_index = '0;
      req_bus.sample_in     = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_reset_coefficients();
      check_rounding();
      check_unmapped_registers();
      check_coefficient_extremes();
      check_butterworth_streams();
      check_output_backpressure();
      check_sender_pause();
      check_random_coefficients();

      drain_outputs();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS third_order_highpass_iir");
      end else begin
         $display("FAIL third_order_highpass_iir");
      end
      $finish;
   end

endmodule
